/* sv/pifdm_pkg.sv */
// Shared types and constants of the PWM input frequency and duty meter.
// No dependencies; every other file of the block refers to this package.
`default_nettype none

package pifdm_pkg;

   // Default counter width of the capture timer.
   localparam int COUNTER_BITS_DEFAULT = 16;

   // Field widths of the channels.
   localparam int CAP_W      = 16;
   localparam int TICK_W     = 16;
   localparam int FREQ_W     = 37;
   localparam int DUTY_W     = 15;
   localparam int CLK_W      = 29;
   localparam int PRE_W      = 16;
   localparam int CSR_DATA_W = 29;
   localparam int CSR_IDX_W  = 1;

   // Result word layout, lowest field first, padded to whole bytes.
   localparam int RSP_PERIOD_LSB = 0;
   localparam int RSP_HIGH_LSB   = RSP_PERIOD_LSB + TICK_W;
   localparam int RSP_FREQ_LSB   = RSP_HIGH_LSB + TICK_W;
   localparam int RSP_DUTY_LSB   = RSP_FREQ_LSB + FREQ_W;
   localparam int RSP_USED_W     = RSP_DUTY_LSB + DUTY_W;
   localparam int RSP_DATA_W     = ((RSP_USED_W + 7) / 8) * 8;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_CLOCK    = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_PRESCALE = 1'b1;

   // Reset values of the configuration registers.
   localparam logic [CLK_W-1:0] CLK_HZ_RESET   = 29'd180000000;
   localparam logic [PRE_W-1:0] PRESCALE_RESET = 16'd179;

   // Arithmetic constants.
   localparam int               FREQ_FRAC = 8;
   localparam logic [DUTY_W-1:0] DUTY_FULL = 15'd25600;

   // Iteration counts of the shared divider.
   localparam int DIV_CNT_W = 6;
   localparam int FREQ_ITER = FREQ_W;
   localparam int DUTY_ITER = DUTY_W;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;      // input transaction taken this cycle
      logic mul_load;    // register the divisor and duty numerator products
      logic div_start;   // start the divider
      logic div_duty;    // divider operand select: duty when set, frequency otherwise
      logic freq_store;  // keep the divider quotient as frequency
      logic duty_store;  // keep the divider quotient as duty
      logic duty_sat;    // set duty to full scale
      logic load_out;    // load the result register and restart from the closing edge
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic closing;          // current input closes a period
      logic period_zero;
      logic width_zero;
      logic width_ge_period;
      logic div_done;
      logic out_free;         // result register can take a new result
   } dp_status_type;

endpackage

`default_nettype wire

/* sv/pifdm_div.sv */
// Shared restoring divider, one quotient bit per cycle.
// Depends on pifdm_pkg for widths and iteration counts.
`default_nettype none

module pifdm_div #(
   parameter int COUNTER_BITS = pifdm_pkg::COUNTER_BITS_DEFAULT,
   localparam int DenW = COUNTER_BITS + pifdm_pkg::PRE_W + 1,
   localparam int NumW = (COUNTER_BITS + pifdm_pkg::DUTY_W > pifdm_pkg::FREQ_W) ?
                         COUNTER_BITS + pifdm_pkg::DUTY_W : pifdm_pkg::FREQ_W
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   start,
   input  wire logic                                   duty_op,
   input  wire logic [NumW-1:0]                        num_i,
   input  wire logic [DenW-1:0]                        den_i,
   output logic                                        busy,
   output logic                                        done,
   output logic [pifdm_pkg::FREQ_W-1:0]                quo
);

   localparam int FreqShift = NumW - pifdm_pkg::FREQ_ITER;
   localparam int DutyShift = NumW - pifdm_pkg::DUTY_ITER;

   logic [DenW-1:0]                     rem_ff;
   logic [DenW-1:0]                     den_ff;
   logic [NumW-1:0]                     num_ff;
   logic [pifdm_pkg::FREQ_W-1:0]        quo_ff;
   logic [pifdm_pkg::DIV_CNT_W-1:0]     cnt_ff;
   logic                                busy_ff;
   logic                                done_ff;
   logic [DenW:0]                       rem_sh;
   logic                                fits;
   logic [DenW-1:0]                     rem_in;

   // One trial subtraction of the divisor from the shifted partial remainder.
   assign rem_sh = {rem_ff, num_ff[NumW-1]};
   assign fits   = rem_sh >= {1'b0, den_ff};
   assign rem_in = fits ? DenW'(rem_sh - {1'b0, den_ff}) : DenW'(rem_sh);

   // Control: busy while iterations remain, one-cycle done pulse after the last.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= duty_op ? pifdm_pkg::DIV_CNT_W'(pifdm_pkg::DUTY_ITER)
                               : pifdm_pkg::DIV_CNT_W'(pifdm_pkg::FREQ_ITER);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == pifdm_pkg::DIV_CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Operands. The duty quotient is known to be below 2^15, so its top
   // numerator bits are preloaded as the partial remainder.
   always_ff @(posedge clock) begin
      if (start) begin
         den_ff <= den_i;
         quo_ff <= '0;
         if (duty_op) begin
            rem_ff <= DenW'(num_i >> pifdm_pkg::DUTY_ITER);
            num_ff <= num_i << DutyShift;
         end else begin
            rem_ff <= '0;
            num_ff <= num_i << FreqShift;
         end
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         num_ff <= {num_ff[NumW-2:0], 1'b0};
         quo_ff <= {quo_ff[pifdm_pkg::FREQ_W-2:0], fits};
      end
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

`default_nettype wire

/* sv/pifdm_dp.sv */
// Datapath of the meter: edge registers, configuration, products, divider, result register.
// Depends on pifdm_pkg and pifdm_div.
`default_nettype none

module pifdm_dp #(
   parameter int COUNTER_BITS = pifdm_pkg::COUNTER_BITS_DEFAULT
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire pifdm_pkg::ctrl_cmd_type               cmd,
   output pifdm_pkg::dp_status_type                   status,
   input  wire logic [pifdm_pkg::CAP_W-1:0]           req_tdata,
   input  wire logic                                  csr_we,
   input  wire logic [pifdm_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [pifdm_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   output logic [pifdm_pkg::RSP_DATA_W-1:0]           rsp_tdata
);

   localparam int CapW = (COUNTER_BITS < pifdm_pkg::CAP_W) ? COUNTER_BITS : pifdm_pkg::CAP_W;
   localparam int DenW = COUNTER_BITS + pifdm_pkg::PRE_W + 1;
   localparam int NumW = (COUNTER_BITS + pifdm_pkg::DUTY_W > pifdm_pkg::FREQ_W) ?
                         COUNTER_BITS + pifdm_pkg::DUTY_W : pifdm_pkg::FREQ_W;

   logic [pifdm_pkg::CLK_W-1:0]   clk_hz_ff;
   logic [pifdm_pkg::PRE_W-1:0]   pre_ff;
   logic [COUNTER_BITS-1:0]       start_ff;
   logic [COUNTER_BITS-1:0]       fall_ff;
   logic [COUNTER_BITS-1:0]       width_ff;
   logic [COUNTER_BITS-1:0]       close_ff;
   logic [COUNTER_BITS-1:0]       period_ff;
   logic [pifdm_pkg::FREQ_W-1:0]  last_freq_ff;
   logic [pifdm_pkg::DUTY_W-1:0]  last_duty_ff;
   logic [DenW-1:0]               den_ff;
   logic [NumW-1:0]               dnum_ff;
   logic                          rsp_valid_ff;
   logic [pifdm_pkg::RSP_DATA_W-1:0] rsp_data_ff;

   logic [COUNTER_BITS-1:0]       cap;
   logic                          cap_zero;
   logic [COUNTER_BITS-1:0]       diff;
   logic [pifdm_pkg::PRE_W:0]     pre_plus;
   logic [NumW-1:0]               div_num;
   logic [DenW-1:0]               div_den;
   logic                          div_busy;
   logic                          div_done;
   logic [pifdm_pkg::FREQ_W-1:0]  div_quo;

   // Capture reduced to the counter width; the difference wraps at that width.
   assign cap      = COUNTER_BITS'(req_tdata[CapW-1:0]);
   assign cap_zero = (cap == '0);
   assign diff     = cap - start_ff;
   assign pre_plus = {1'b0, pre_ff} + 1'b1;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         clk_hz_ff <= pifdm_pkg::CLK_HZ_RESET;
         pre_ff    <= pifdm_pkg::PRESCALE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            pifdm_pkg::CSR_IDX_CLOCK: begin
               clk_hz_ff <= csr_wdata[pifdm_pkg::CLK_W-1:0];
            end
            pifdm_pkg::CSR_IDX_PRESCALE: begin
               pre_ff <= csr_wdata[pifdm_pkg::PRE_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Edge phase state and held results.
   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff     <= '0;
         fall_ff      <= '0;
         width_ff     <= '0;
         last_freq_ff <= '0;
         last_duty_ff <= '0;
      end else begin
         if (cmd.accept && !cap_zero) begin
            priority if (start_ff == '0) begin
               start_ff <= cap;
            end else if (fall_ff == '0) begin
               fall_ff  <= cap;
               width_ff <= diff;
            end else begin
            end
         end
         if (cmd.freq_store) begin
            last_freq_ff <= div_quo;
         end
         if (cmd.duty_store) begin
            last_duty_ff <= div_quo[pifdm_pkg::DUTY_W-1:0];
         end else if (cmd.duty_sat) begin
            last_duty_ff <= pifdm_pkg::DUTY_FULL;
         end
         if (cmd.load_out) begin
            start_ff <= close_ff;
            fall_ff  <= '0;
         end
      end
   end

   // Closing edge, period and the two products that feed the divider.
   always_ff @(posedge clock) begin
      if (cmd.accept && status.closing) begin
         close_ff  <= cap;
         period_ff <= diff;
      end
      if (cmd.mul_load) begin
         den_ff  <= DenW'(pre_plus) * DenW'(period_ff);
         dnum_ff <= NumW'(width_ff) * NumW'(pifdm_pkg::DUTY_FULL);
      end
   end

   // Divider operands: clock times 256 over the product, or the duty numerator over the period.
   assign div_num = cmd.div_duty ? dnum_ff
                                 : NumW'({clk_hz_ff, {pifdm_pkg::FREQ_FRAC{1'b0}}});
   assign div_den = cmd.div_duty ? DenW'(period_ff) : den_ff;

   pifdm_div #(
      .COUNTER_BITS (COUNTER_BITS)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.div_start),
      .duty_op (cmd.div_duty),
      .num_i   (div_num),
      .den_i   (div_den),
      .busy    (div_busy),
      .done    (div_done),
      .quo     (div_quo)
   );

   // Result register; a new result may enter as the old one is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_data_ff <= pifdm_pkg::RSP_DATA_W'({last_duty_ff, last_freq_ff,
                                                pifdm_pkg::TICK_W'(width_ff),
                                                pifdm_pkg::TICK_W'(period_ff)});
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Status toward the controller.
   always_comb begin
      status.closing         = !cap_zero && (start_ff != '0) && (fall_ff != '0);
      status.period_zero     = (period_ff == '0);
      status.width_zero      = (width_ff == '0);
      status.width_ge_period = (width_ff >= period_ff);
      status.div_done        = div_done && !div_busy;
      status.out_free        = !rsp_valid_ff || rsp_tready;
   end

endmodule

`default_nettype wire

/* sv/pifdm_ctrl.sv */
// Controller state machine of the meter: sequences products, divisions and result load.
// Depends on pifdm_pkg for the command and status types.
`default_nettype none

module pifdm_ctrl (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   input  wire pifdm_pkg::dp_status_type status,
   output pifdm_pkg::ctrl_cmd_type       cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_MUL    = 3'd1;
   localparam logic [2:0] S_FSTART = 3'd2;
   localparam logic [2:0] S_FWAIT  = 3'd3;
   localparam logic [2:0] S_DSTART = 3'd4;
   localparam logic [2:0] S_DWAIT  = 3'd5;
   localparam logic [2:0] S_DONE   = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            cmd.accept = req_tvalid;
            if (req_tvalid && status.closing) begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul_load = 1'b1;
            state_in     = status.period_zero ? S_DONE : S_FSTART;
         end
         S_FSTART: begin
            cmd.div_start = 1'b1;
            state_in      = S_FWAIT;
         end
         S_FWAIT: begin
            if (status.div_done) begin
               cmd.freq_store = 1'b1;
               priority if (status.width_zero) begin
                  state_in = S_DONE;
               end else if (status.width_ge_period) begin
                  cmd.duty_sat = 1'b1;
                  state_in     = S_DONE;
               end else begin
                  state_in = S_DSTART;
               end
            end
         end
         S_DSTART: begin
            cmd.div_start = 1'b1;
            cmd.div_duty  = 1'b1;
            state_in      = S_DWAIT;
         end
         S_DWAIT: begin
            cmd.div_duty = 1'b1;
            if (status.div_done) begin
               cmd.duty_store = 1'b1;
               state_in       = S_DONE;
            end
         end
         S_DONE: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);

endmodule

`default_nettype wire

/* sv/pwm_input_freq_duty_meter_unit.sv */
// PWM input meter: period, high time, frequency and duty from edge capture timestamps.
//
// The req channel carries one capture timestamp per signal edge in req_tdata.
// A zero capture is dropped. The first capture is taken as a rising edge, the
// next as the falling edge and the third closes the period; that closing edge
// then becomes the next rising edge. Only a closing edge makes a result on the
// rsp channel: period ticks, high ticks, frequency in Q8 hertz and duty percent
// in Q8, saturated at 100 percent.
// An edge that makes no result is taken in the cycle it is offered while the meter
// is idle. A closing edge keeps req_tready low until its result is in the output
// register; the time is set by the shared restoring divider, which spends 37
// iterations on the frequency and 15 on the duty (the duty pass is skipped
// when the high time is zero or not below the period).
// The output register lets the next edges be taken while a result waits; if
// the receiver stalls, the following result waits in the controller until the
// register is free. Reset (synchronous) clears the edge phase state and the held
// results and loads configuration defaults. The user writes configuration via csr_we,
// csr_index and csr_wdata only while the meter is idle; the block does not enforce it.
// Depends on pifdm_pkg, pifdm_ctrl, pifdm_dp and pifdm_div.
`default_nettype none

module pwm_input_freq_duty_meter_unit #(
   parameter int COUNTER_BITS = pifdm_pkg::COUNTER_BITS_DEFAULT
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   input  wire logic [pifdm_pkg::CAP_W-1:0]           req_tdata,   // capture_value
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   // period_ticks, high_ticks, frequency_q8, duty_q8, zero padding
   output logic [pifdm_pkg::RSP_DATA_W-1:0]           rsp_tdata,
   input  wire logic                                  csr_we,
   input  wire logic [pifdm_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [pifdm_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   pifdm_pkg::ctrl_cmd_type  cmd;
   pifdm_pkg::dp_status_type status;

   pifdm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   pifdm_dp #(
      .COUNTER_BITS (COUNTER_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // A result is loaded only when the previous one is gone or being taken.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_tvalid || rsp_tready))
      else $error("result register overwritten before transfer");

   // A loaded result is offered on the next cycle.
   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> rsp_tvalid)
      else $error("loaded result not offered");

   // The divider finishes only while a closing edge is in work.
   a_div_in_work: assert property (@(posedge clock) disable iff (reset)
      status.div_done |-> !req_tready)
      else $error("divider finished while the meter was idle");

   // Duty never exceeds full scale.
   a_duty_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[pifdm_pkg::RSP_DUTY_LSB +: pifdm_pkg::DUTY_W]
                      <= pifdm_pkg::DUTY_FULL))
      else $error("duty above full scale");

endmodule

`default_nettype wire
